// ===== rtl/mpo_pkg.sv =====
// Shared constants, codes and types of the multi-waveform phase oscillator.
`default_nettype none

package mpo_pkg;

    // Build-time settings
    localparam int BLEP_WINDOW     = 2;
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;

    localparam logic [31:0] PHASE_KEEP = 32'hFFFF_FFFF << (32 - PHASE_BITS);

    // Shared multiplier
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Serial divider for the edge distance: |t| with 30 fraction bits over the increment
    localparam int DIV_QBITS = 30 + $clog2(BLEP_WINDOW);
    localparam int DIV_NW    = 62;
    localparam int DIV_CW    = $clog2(DIV_QBITS + 1);

    // Q2.30 constants
    localparam logic signed [MUL_W-1:0] ONE_Q30   = 33'sd1073741824;
    localparam logic signed [MUL_W-1:0] HALF_Q30  = 33'sd536870912;
    localparam logic signed [MUL_W-1:0] THREE_Q30 = 33'sd3221225472;
    localparam logic signed [MUL_W-1:0] SIN_A1    = 33'sd1686629713;
    localparam logic signed [MUL_W-1:0] SIN_A3    = -33'sd693598671;
    localparam logic signed [MUL_W-1:0] SIN_A5    = 33'sd80710782;
    // ceil(2^34 / 6): exact floor division by six for 32-bit operands
    localparam logic signed [MUL_W-1:0] RECIP6    = 33'sh0_AAAA_AAAB;

    // Control mode bits
    localparam int MODE_AA = 3;
    localparam int MODE_AM = 4;
    localparam int MODE_FM = 5;

    typedef enum logic [2:0] {
        WF_SINE, WF_SQUARE, WF_SAW, WF_TRIANGLE, WF_PULSE
    } wave_t;

    typedef enum logic [1:0] {
        REQ_TICK, REQ_LOAD, REQ_EXT, REQ_UNKNOWN
    } req_t;

    typedef enum logic [2:0] {
        CFG_BASE_INC, CFG_MODE, CFG_GAIN, CFG_PULSE_W,
        CFG_AM_DEPTH, CFG_AM_INC, CFG_FM_DEPTH, CFG_FM_INC
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_CAR, SEL_AM, SEL_FM
    } sine_sel_t;

    typedef enum logic [4:0] {
        S_IDLE, S_START,
        S_SIN0, S_SIN1, S_SIN2, S_SIN3, S_SIN4,
        S_EDGE, S_DIVW, S_B1, S_B2, S_B3, S_EACC, S_WFIN,
        S_AM, S_AM1, S_AM2, S_AM3,
        S_FM, S_FM1, S_FM2,
        S_OUT0, S_OUT1, S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/mpo_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module mpo_mul
    import mpo_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/mpo_div.sv =====
// Restoring divider, one quotient bit a cycle, for the edge distance over the increment.
`default_nettype none

module mpo_div
    import mpo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          mag,
    input  logic [31:0]          divisor,
    output logic [DIV_QBITS-1:0] quot,
    output logic                 done
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CW-1:0]    cnt_reg;
    logic [31:0]          rem_reg;
    logic [DIV_NW-1:0]    sh_reg;
    logic [DIV_QBITS-1:0] quot_reg;
    logic [DIV_NW-1:0]    dividend;
    logic [32:0]          trial;
    logic                 ge;

    assign dividend = {mag, 30'b0};
    assign trial    = {rem_reg, sh_reg[DIV_NW-1]};
    assign ge       = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_QBITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // remainder starts below the divisor since the quotient fits DIV_QBITS
            rem_reg  <= 32'(dividend >> DIV_QBITS);
            sh_reg   <= dividend << (DIV_NW - DIV_QBITS);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];
            sh_reg   <= sh_reg << 1;
            quot_reg <= {quot_reg[DIV_QBITS-2:0], ge};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/multiwave_phase_oscillator.sv =====
// Multi-waveform phase-accumulator oscillator: sequencer, datapath and configuration.
//
// One request in, one sample out. A request is taken only while the sequencer is idle; every
// multiplication goes through one shared 33x33 multiplier, one product a cycle. A load-phase
// or unknown request goes from its start state straight to the emit state. A tick runs the
// carrier sine for the sine waveform, then AM (its sine and two products) and FM (its sine
// and one product) where they are on. With the edge correction on, square, saw and pulse test
// their edges (one for saw, two for square and pulse); an edge inside the window takes its
// scaled distance from a serial divider at one bit a cycle, and the polynomial steps are
// skipped when that distance lies beyond one. A finished sample waits in the output register;
// the next request is taken meanwhile and only its own result waits for that register to
// empty.
`default_nettype none

module multiwave_phase_oscillator
    import mpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // phase_value[31:0], external_mod[63:32]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // sample_out[15:0], phase_now[47:16]
    output logic [0:0]  m_tuser,   // saturated[0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    // Configuration
    logic [31:0] base_inc_reg;
    logic [5:0]  mode_reg;
    logic [15:0] gain_cfg_reg;
    logic [15:0] pulse_w_reg;
    logic [15:0] am_depth_reg;
    logic [31:0] am_inc_reg;
    logic [30:0] fm_depth_reg;
    logic [31:0] fm_inc_reg;

    // Control and phase state
    state_t      state_reg, state_next;
    sine_sel_t   sel_reg;
    logic        edge_sel_reg;
    logic        t_neg_reg;
    logic [31:0] carrier_phase_reg;
    logic [31:0] am_phase_reg;
    logic [31:0] fm_phase_reg;
    logic        out_valid_reg;

    // Request and datapath
    logic [1:0]               req_reg;
    logic [31:0]              phase_in_reg;
    logic [31:0]              ext_reg;
    logic [30:0]              u_reg;
    logic [30:0]              u2_reg;
    logic signed [31:0]       sine_reg;
    logic signed [MUL_W-1:0]  s_reg;
    logic [30:0]              i_reg;
    logic signed [MUL_W-1:0]  corr_reg;
    logic signed [MUL_W-1:0]  wave_reg;
    logic signed [18:0]       gain_reg;
    logic [31:0]              step_reg;
    logic [15:0]              res_sample_reg;
    logic                     res_sat_reg;
    logic [15:0]              out_sample_reg;
    logic                     out_sat_reg;
    logic [31:0]              out_phase_reg;

    // Shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic [DIV_QBITS-1:0]     div_quot;
    logic                     div_done;

    mpo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Combinational datapath terms
    logic [2:0]  wf;
    logic        blep_en, am_on, fm_on, emit_ok;
    logic [31:0] p;
    logic [31:0] sin_ph;
    logic [1:0]  quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS:0]   k;
    logic [30:0] u;
    logic signed [MUL_W-1:0] in3, in1, in1_c, v, sine_val;
    logic signed [16:0] sin17;
    logic signed [15:0] sin15;
    logic [31:0] mag;
    logic [35:0] win;
    logic        present;
    logic signed [DIV_QBITS+1:0] s_full;
    logic        s_lo, s_hi;
    logic [28:0] q6;
    logic signed [MUL_W-1:0] inner, isum, delta;
    logic signed [18:0] factor;
    logic signed [34:0] y;

    assign p       = carrier_phase_reg;
    assign wf      = mode_reg[2:0];
    assign blep_en = (req_reg == REQ_TICK) && mode_reg[MODE_AA] && (base_inc_reg != 32'd0);
    assign am_on   = (req_reg == REQ_TICK) && mode_reg[MODE_AM] && (am_inc_reg != 32'd0);
    assign fm_on   = (req_reg == REQ_TICK) && mode_reg[MODE_FM] && (fm_inc_reg != 32'd0);
    assign emit_ok = !out_valid_reg || m_tready;

    always_comb
    begin
        case (sel_reg)
            SEL_AM:  sin_ph = am_phase_reg;
            SEL_FM:  sin_ph = fm_phase_reg;
            default: sin_ph = carrier_phase_reg;
        endcase
    end

    // Quarter-wave lookup: mirror on odd quadrants, negate on the lower half
    assign quad = sin_ph[31:30];
    assign idx  = sin_ph[29 -: SINE_TABLE_BITS];
    assign k    = quad[0] ? ((SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS) - {1'b0, idx}
                          : {1'b0, idx};
    assign u    = 31'(k) << (30 - SINE_TABLE_BITS);

    assign in3      = SIN_A3 + $signed(prod[62:30]);
    assign in1      = SIN_A1 + $signed(prod[62:30]);
    assign in1_c    = in1[MUL_W-1] ? '0 : in1;
    assign v        = ($signed(prod[62:30]) > ONE_Q30) ? ONE_Q30 : $signed(prod[62:30]);
    assign sine_val = quad[1] ? -v : v;

    assign sin17 = sine_reg[31:15];
    assign sin15 = (sin17 > 17'sd32767) ? 16'sd32767 : sin17[15:0];

    // Edge distance: edge 0 sits at half a cycle, edge 1 at the wrap
    always_comb
    begin
        if (edge_sel_reg)
            mag = p;
        else if (p[31])
            mag = {1'b0, p[30:0]};
        else
            mag = 32'h8000_0000 - p;
    end
    assign win     = 36'({4'b0, base_inc_reg} * 36'(BLEP_WINDOW));
    assign present = {4'b0, mag} < win;

    assign s_full = t_neg_reg ? -$signed((DIV_QBITS+2)'(div_quot))
                              : $signed((DIV_QBITS+2)'(div_quot));
    assign s_lo   = s_full < -(DIV_QBITS+2)'(ONE_Q30);
    assign s_hi   = s_full > (DIV_QBITS+2)'(ONE_Q30);

    assign q6    = prod[62:34];
    assign inner = HALF_Q30 - MUL_W'(q6);
    assign isum  = HALF_Q30 + $signed(prod[62:30]);
    assign delta = !edge_sel_reg ? MUL_W'(i_reg)
                 : (wf == WF_SAW) ? -(MUL_W'(i_reg) <<< 1) : -MUL_W'(i_reg);

    assign factor = 19'sd65536 - 19'(am_depth_reg) + 19'($signed(prod[32:15]));
    assign y      = $signed(prod[65:31]);

    mpo_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (mag),
        .divisor (base_inc_reg),
        .quot    (div_quot),
        .done    (div_done)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_START;
            S_START:
            begin
                if (req_reg inside {REQ_LOAD, REQ_UNKNOWN})
                    state_next = S_EMIT;
                else if (wf == WF_SINE)
                    state_next = S_SIN0;
                else if (blep_en && (wf inside {WF_SQUARE, WF_SAW, WF_PULSE}))
                    state_next = S_EDGE;
                else
                    state_next = S_AM;
            end
            S_SIN0: state_next = S_SIN1;
            S_SIN1: state_next = S_SIN2;
            S_SIN2: state_next = S_SIN3;
            S_SIN3: state_next = S_SIN4;
            S_SIN4:
            begin
                case (sel_reg)
                    SEL_AM:  state_next = S_AM1;
                    SEL_FM:  state_next = S_FM1;
                    default: state_next = S_AM;
                endcase
            end
            S_EDGE:
            begin
                if (present)
                    state_next = S_DIVW;
                else if (edge_sel_reg)
                    state_next = S_WFIN;
            end
            S_DIVW:
            begin
                if (div_done)
                    state_next = (s_lo || s_hi) ? S_EACC : S_B1;
            end
            S_B1:   state_next = S_B2;
            S_B2:   state_next = S_B3;
            S_B3:   state_next = S_EACC;
            S_EACC: state_next = edge_sel_reg ? S_WFIN : S_EDGE;
            S_WFIN: state_next = S_AM;
            S_AM:   state_next = am_on ? S_SIN0 : S_FM;
            S_AM1:  state_next = S_AM2;
            S_AM2:  state_next = S_AM3;
            S_AM3:  state_next = S_FM;
            S_FM:   state_next = fm_on ? S_SIN0 : S_OUT0;
            S_FM1:  state_next = S_FM2;
            S_FM2:  state_next = S_OUT0;
            S_OUT0: state_next = S_OUT1;
            S_OUT1: state_next = S_EMIT;
            S_EMIT:
                if (emit_ok)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, multiplier operands, divider start
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_SIN0:
            begin
                mul_a = MUL_W'(u);
                mul_b = MUL_W'(u);
            end
            S_SIN1:
            begin
                mul_a = MUL_W'(prod[60:30]);
                mul_b = SIN_A5;
            end
            S_SIN2:
            begin
                mul_a = MUL_W'(u2_reg);
                mul_b = in3;
            end
            S_SIN3:
            begin
                mul_a = MUL_W'(u_reg);
                mul_b = in1_c;
            end
            S_EDGE: div_start = present;
            S_DIVW:
            begin
                mul_a = MUL_W'(s_full);
                mul_b = MUL_W'(s_full);
            end
            S_B1:
            begin
                mul_a = MUL_W'(prod[60:30]);
                mul_b = RECIP6;
            end
            S_B2:
            begin
                mul_a = s_reg;
                mul_b = inner;
            end
            S_AM1:
            begin
                mul_a = MUL_W'(am_depth_reg);
                mul_b = MUL_W'(sin15);
            end
            S_AM2:
            begin
                mul_a = MUL_W'(gain_cfg_reg);
                mul_b = MUL_W'(factor);
            end
            S_FM1:
            begin
                mul_a = MUL_W'(fm_depth_reg);
                mul_b = MUL_W'(sin15);
            end
            S_OUT0:
            begin
                mul_a = wave_reg;
                mul_b = MUL_W'(gain_reg);
            end
            default: s_tready = 1'b0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_inc_reg <= '0;
            mode_reg     <= '0;
            gain_cfg_reg <= '0;
            pulse_w_reg  <= 16'd32768;
            am_depth_reg <= '0;
            am_inc_reg   <= '0;
            fm_depth_reg <= '0;
            fm_inc_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_BASE_INC: base_inc_reg <= cfg_wdata;
                CFG_MODE:     mode_reg     <= cfg_wdata[5:0];
                CFG_GAIN:     gain_cfg_reg <= cfg_wdata[15:0];
                CFG_PULSE_W:  pulse_w_reg  <= cfg_wdata[15:0];
                CFG_AM_DEPTH: am_depth_reg <= cfg_wdata[15:0];
                CFG_AM_INC:   am_inc_reg   <= cfg_wdata;
                CFG_FM_DEPTH: fm_depth_reg <= cfg_wdata[30:0];
                CFG_FM_INC:   fm_inc_reg   <= cfg_wdata;
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    // Control state and phase accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sel_reg           <= SEL_CAR;
            edge_sel_reg      <= 1'b0;
            carrier_phase_reg <= '0;
            am_phase_reg      <= '0;
            fm_phase_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && emit_ok)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_START:
                begin
                    sel_reg      <= SEL_CAR;
                    edge_sel_reg <= (wf == WF_SAW);
                    if (req_reg == REQ_LOAD)
                        carrier_phase_reg <= phase_in_reg & PHASE_KEEP;
                end
                S_EDGE:
                    if (!present)
                        edge_sel_reg <= 1'b1;
                S_EACC: edge_sel_reg <= 1'b1;
                S_AM:   sel_reg      <= SEL_AM;
                S_AM3:  am_phase_reg <= (am_phase_reg + am_inc_reg) & PHASE_KEEP;
                S_FM:   sel_reg      <= SEL_FM;
                S_FM2:  fm_phase_reg <= (fm_phase_reg + fm_inc_reg) & PHASE_KEEP;
                S_OUT0: carrier_phase_reg <= (carrier_phase_reg + step_reg) & PHASE_KEEP;
                default: sel_reg <= sel_reg;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_reg      <= s_tuser;
                phase_in_reg <= s_tdata[31:0];
                ext_reg      <= s_tdata[63:32];
            end
            S_START:
            begin
                res_sample_reg <= '0;
                res_sat_reg    <= 1'b0;
                corr_reg       <= '0;
                case (wf)
                    WF_SQUARE:   wave_reg <= p[31] ? -ONE_Q30 : ONE_Q30;
                    WF_SAW:      wave_reg <= MUL_W'({1'b0, p[31:1]}) - ONE_Q30;
                    WF_TRIANGLE: wave_reg <= p[31] ? THREE_Q30 - MUL_W'(p)
                                                   : MUL_W'(p) - ONE_Q30;
                    WF_PULSE:    wave_reg <= (p < {pulse_w_reg, 16'b0}) ? ONE_Q30 : -ONE_Q30;
                    default:     wave_reg <= '0;
                endcase
            end
            S_SIN0: u_reg  <= u;
            S_SIN1: u2_reg <= prod[60:30];
            S_SIN4:
            begin
                sine_reg <= 32'(sine_val);
                if (sel_reg == SEL_CAR)
                    wave_reg <= sine_val;
            end
            S_EDGE: t_neg_reg <= !edge_sel_reg && !p[31];
            S_DIVW:
            begin
                s_reg <= MUL_W'(s_full);
                if (s_lo)
                    i_reg <= '0;
                else if (s_hi)
                    i_reg <= 31'(ONE_Q30);
            end
            S_B3:   i_reg    <= isum[30:0];
            S_EACC: corr_reg <= corr_reg + delta;
            S_WFIN: wave_reg <= wave_reg + ((wf == WF_PULSE) ? (corr_reg >>> 1) : corr_reg);
            S_AM:
                if (!am_on)
                    gain_reg <= 19'(gain_cfg_reg);
            S_AM3:  gain_reg <= $signed(prod[34:16]);
            S_FM:   step_reg <= (req_reg == REQ_EXT) ? base_inc_reg + ext_reg : base_inc_reg;
            S_FM2:  step_reg <= step_reg + prod[46:15];
            S_OUT1:
            begin
                // clip to Q1.15
                if (y > 35'sd32767)
                begin
                    res_sample_reg <= 16'h7FFF;
                    res_sat_reg    <= 1'b1;
                end
                else if (y < -35'sd32768)
                begin
                    res_sample_reg <= 16'h8000;
                    res_sat_reg    <= 1'b1;
                end
                else
                begin
                    res_sample_reg <= y[15:0];
                    res_sat_reg    <= 1'b0;
                end
            end
            S_EMIT:
                if (emit_ok)
                begin
                    out_sample_reg <= res_sample_reg;
                    out_sat_reg    <= res_sat_reg;
                    out_phase_reg  <= carrier_phase_reg;
                end
            default: u_reg <= u_reg;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_phase_reg, out_sample_reg};
    assign m_tuser  = out_sat_reg;

    // Checks
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVW)
        else $error("divider finished outside its wait state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_START)
        else $error("accepted request did not start the sequencer");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[15:0] == 16'h7FFF || m_tdata[15:0] == 16'h8000))
        else $error("saturation flag without a clipped sample");

    a_phase_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (carrier_phase_reg & ~PHASE_KEEP) == 32'd0)
        else $error("carrier phase holds bits below the kept width");

endmodule

`default_nettype wire

// ===== tb/multiwave_phase_oscillator_test.sv =====
// Self-checking testbench for the multi-waveform phase oscillator.
`default_nettype none

module multiwave_phase_oscillator_test;
    import mpo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LIMIT_CYCLES = 1500000;

    typedef struct {
        logic [15:0] sample;
        logic        sat;
        logic [31:0] phase;
    } sample_t;

    // Predictor of the oscillator with its own copy of state and registers
    class osc_scoreboard;
        logic [31:0] base_inc, am_inc, fm_inc, fm_dep;
        logic [5:0]  mode;
        logic [15:0] gain_reg, pw, am_dep;
        logic [31:0] car_ph, am_ph, fm_ph;
        sample_t     pending[$];
        int          mismatches;
        int          matched;

        function new();
            base_inc = 0; am_inc = 0; fm_inc = 0; fm_dep = 0;
            mode = 0; gain_reg = 0; pw = 16'd32768; am_dep = 0;
            car_ph = 0; am_ph = 0; fm_ph = 0;
            mismatches = 0; matched = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_BASE_INC: base_inc = val;
                CFG_MODE:     mode     = val[5:0];
                CFG_GAIN:     gain_reg = val[15:0];
                CFG_PULSE_W:  pw       = val[15:0];
                CFG_AM_DEPTH: am_dep   = val[15:0];
                CFG_AM_INC:   am_inc   = val;
                CFG_FM_DEPTH: fm_dep   = {1'b0, val[30:0]};
                CFG_FM_INC:   fm_inc   = val;
                default: ;
            endcase
        endfunction

        function longint fshr(longint x, int n);
            return x >>> n;
        endfunction

        function longint quarter(int k);
            longint u, u2, in3, in1, v;
            u = longint'(k) << (30 - SINE_TABLE_BITS);
            u2 = (u * u) >>> 30;
            in3 = longint'(SIN_A3) + ((u2 * longint'(SIN_A5)) >>> 30);
            in1 = longint'(SIN_A1) + fshr(u2 * in3, 30);
            if (in1 < 0)
                in1 = 0;
            v = (u * in1) >>> 30;
            return v > (64'sd1 << 30) ? (64'sd1 << 30) : v;
        endfunction

        function longint sin30(logic [31:0] p);
            int idx, k;
            longint v;
            idx = (p >> (30 - SINE_TABLE_BITS)) & ((1 << SINE_TABLE_BITS) - 1);
            k = p[30] ? ((1 << SINE_TABLE_BITS) - idx) : idx;
            v = quarter(k);
            return p[31] ? -v : v;
        endfunction

        function longint sin15(logic [31:0] p);
            longint v;
            v = fshr(sin30(p), 15);
            return v > 32767 ? 32767 : v;
        endfunction

        function longint integral(longint s);
            longint one, inner;
            one = 64'sd1 << 30;
            if (s < -one)
                return 0;
            if (s > one)
                return one;
            inner = (one >>> 1) - ((s * s) >>> 30) / 6;
            return (one >>> 1) + fshr(s * inner, 30);
        endfunction

        // Edge correction; hit says whether the edge lies inside the window
        function longint edge_corr(longint t, output bit hit);
            longint inc, mag;
            inc = longint'(base_inc);
            mag = t < 0 ? -t : t;
            hit = 0;
            if (inc == 0 || mag >= inc * BLEP_WINDOW)
                return 0;
            hit = 1;
            return integral((t * (64'sd1 << 30)) / inc);
        endfunction

        function longint square_corr(logic [31:0] p);
            bit hit;
            longint c, v;
            c = 0;
            v = edge_corr(longint'(p) - (64'sd1 << 31), hit);
            if (hit)
                c = v;
            v = edge_corr(longint'(p), hit);
            if (hit)
                c -= v;
            return c;
        endfunction

        function longint waveform(logic [31:0] p, bit blep);
            longint one, v, c;
            bit hit;
            one = 64'sd1 << 30;
            case (mode[2:0])
                WF_SINE:   return sin30(p);
                WF_SQUARE:
                begin
                    v = !p[31] ? one : -one;
                    return blep ? v + square_corr(p) : v;
                end
                WF_SAW:
                begin
                    v = longint'(p >> 1) - one;
                    if (blep)
                    begin
                        c = edge_corr(longint'(p), hit);
                        if (hit)
                            v -= 2 * c;
                    end
                    return v;
                end
                WF_TRIANGLE: return !p[31] ? longint'(p) - one : 3 * one - longint'(p);
                WF_PULSE:
                begin
                    v = (longint'(p) < (longint'(pw) << 16)) ? one : -one;
                    return blep ? v + fshr(square_corr(p), 1) : v;
                end
                default: return 0;
            endcase
        endfunction

        function void note_request(req_t req, logic [31:0] pv, logic [31:0] ext);
            sample_t r;
            longint wv, g, y, d, f;
            logic [31:0] stp;
            r.sat = 0;
            if (req == REQ_LOAD)
                car_ph = pv & PHASE_KEEP;
            if (req inside {REQ_LOAD, REQ_UNKNOWN})
            begin
                r.sample = 0;
                r.phase = car_ph;
                pending.push_back(r);
                return;
            end
            g = longint'(gain_reg);
            if (req == REQ_EXT)
            begin
                wv = waveform(car_ph, 0);
                stp = base_inc + ext;
            end
            else
            begin
                wv = waveform(car_ph, mode[MODE_AA]);
                if (mode[MODE_AM] && am_inc != 0)
                begin
                    d = longint'(am_dep);
                    f = 65536 - d + fshr(d * sin15(am_ph), 15);
                    g = fshr(g * f, 16);
                    am_ph = (am_ph + am_inc) & PHASE_KEEP;
                end
                stp = base_inc;
                if (mode[MODE_FM] && fm_inc != 0)
                begin
                    stp += 32'(fshr(longint'(fm_dep) * sin15(fm_ph), 15));
                    fm_ph = (fm_ph + fm_inc) & PHASE_KEEP;
                end
            end
            car_ph = (car_ph + stp) & PHASE_KEEP;
            y = fshr(wv * g, 31);
            if (y > 32767)
            begin
                y = 32767;
                r.sat = 1;
            end
            else if (y < -32768)
            begin
                y = -32768;
                r.sat = 1;
            end
            r.sample = y[15:0];
            r.phase = car_ph;
            pending.push_back(r);
        endfunction

        function void check_sample(logic [15:0] smp, logic sat, logic [31:0] ph);
            sample_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %0d sat %0d phase %h", $signed(smp), sat, ph);
                return;
            end
            e = pending.pop_front();
            if (e.sample !== smp || e.sat !== sat || e.phase !== ph)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d/%h, got %0d/%0d/%h",
                             $signed(e.sample), e.sat, e.phase, $signed(smp), sat, ph);
            end
            else
                matched++;
        endfunction
    endclass

    logic        clk, rst_n;
    logic        s_tvalid, s_tready, m_tvalid, m_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    osc_scoreboard sb;
    longint cycles;
    bit     quiet;
    int     sent;
    int     settings;

    multiwave_phase_oscillator dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Sample results; stall the receiver in random bursts
    initial
    begin
        int hold;
        hold = 0;
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_sample(m_tdata[15:0], m_tuser[0], m_tdata[47:16]);
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (!quiet && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 8);
            m_tready = (hold == 0);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_we = 1;
        cfg_addr = idx;
        cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic send_request(req_t req, logic [31:0] pv, logic [31:0] ext);
        if (!quiet && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 8)) @(negedge clk);
        s_tvalid = 1;
        s_tuser = req;
        s_tdata = {ext, pv};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(req, pv, ext);
        sent++;
        @(negedge clk);
        s_tvalid = 0;
    endtask

    // Hold until every expected sample has been seen, then let the sequencer settle
    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic random_setup();
        logic [31:0] inc;
        case ($urandom_range(0, 3))
            0: inc = $urandom_range(0, 1 << 20);
            1: inc = $urandom_range(0, 1 << 26);
            2: inc = $urandom;
            default: inc = 32'hFFFF_FFFF;
        endcase
        write_reg(CFG_BASE_INC, inc);
        write_reg(CFG_MODE, $urandom_range(0, 63));
        write_reg(CFG_GAIN, $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom);
        write_reg(CFG_PULSE_W, $urandom);
        write_reg(CFG_AM_DEPTH, $urandom);
        write_reg(CFG_AM_INC, $urandom_range(0, 4) == 0 ? 0 : $urandom);
        write_reg(CFG_FM_DEPTH, $urandom_range(0, 1) ? $urandom_range(0, 1 << 24)
                                                     : ($urandom & 32'h7FFF_FFFF));
        write_reg(CFG_FM_INC, $urandom_range(0, 4) == 0 ? 0 : $urandom);
        settings++;
    endtask

    task automatic random_request();
        int pick;
        req_t req;
        pick = $urandom_range(0, 19);
        req = pick < 14 ? REQ_TICK : (pick < 17 ? REQ_LOAD : (pick < 19 ? REQ_EXT : REQ_UNKNOWN));
        send_request(req, $urandom, $urandom);
    endtask

    initial
    begin
        sb = new();
        quiet = 0; sent = 0; settings = 0;
        rst_n = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = REQ_TICK;
        cfg_we = 0; cfg_addr = CFG_BASE_INC; cfg_wdata = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: reset defaults, then extremes of each waveform with edges in the window
        send_request(REQ_TICK, 0, 0);
        drain();
        write_reg(CFG_BASE_INC, 32'h0100_0000);
        write_reg(CFG_GAIN, 16'hFFFF);
        write_reg(CFG_PULSE_W, 16'h0000);
        write_reg(CFG_AM_DEPTH, 16'hFFFF);
        write_reg(CFG_AM_INC, 0);
        write_reg(CFG_FM_DEPTH, 32'h7FFF_FFFF);
        write_reg(CFG_FM_INC, 0);
        for (int w = 0; w < 8; w++)
        begin
            write_reg(CFG_MODE, w | 8);
            send_request(REQ_LOAD, 32'h7FFF_FFFF, 0);
            send_request(REQ_TICK, 0, 0);
            send_request(REQ_EXT, 32'hFFFF_FFFF, 32'h8000_0000);
            drain();
        end
        write_reg(CFG_MODE, 6'h3F);
        write_reg(CFG_AM_INC, 32'hFFFF_FFFF);
        write_reg(CFG_FM_INC, 32'h4000_0000);
        send_request(REQ_LOAD, 32'hFFFF_FFFF, 0);
        send_request(REQ_UNKNOWN, 32'h1234_5678, 32'h7FFF_FFFF);
        send_request(REQ_TICK, 0, 0);
        send_request(REQ_TICK, 0, 0);
        drain();
        write_reg(CFG_BASE_INC, 0);
        send_request(REQ_TICK, 0, 0);
        send_request(REQ_EXT, 0, 32'h7FFF_FFFF);
        drain();

        // Random phases under a fresh setting each; the last stretch runs without idling
        while (sent < 900)
        begin
            random_setup();
            if (sent > 780)
                quiet = 1;
            repeat ($urandom_range(20, 60))
                random_request();
            drain();
        end
        quiet = 1;
        drain();

        $display("%0d requests under %0d random settings, %0d samples matched, %0d mismatches",
                 sent, settings, sb.matched, sb.mismatches);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== multiwave_phase_oscillator.f =====
rtl/mpo_pkg.sv
rtl/mpo_mul.sv
rtl/mpo_div.sv
rtl/multiwave_phase_oscillator.sv
tb/multiwave_phase_oscillator_test.sv
